// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. All are clocked on clk and disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define CSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked only in cycles where the enable condition holds.
`define CSC_ASSERT_ON(lbl, en, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (en) |-> (prop)) \
		else $error(msg);

`endif

// ===== src/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Types, constants and helper functions of the cleartext sign canonicalizer.
// ----------------------------------------------------------------------------
package csc_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic [1:0] channel;
		logic [7:0] out_byte;
		logic       end_of_run;
		logic       text_done;
		logic       line_too_long;
		logic       space_overflow;
		logic       binary_suspect;
	} result_item_t;

	localparam int unsigned SPACE_DEPTH_DEF = 32;
	localparam int unsigned SPACE_CAP_MAX   = 42;

	localparam logic [15:0] MAX_LINE_RST = 16'd20000;
	localparam logic [15:0] WINDOW_RST   = 16'd8192;
	localparam logic [15:0] LIMIT_RST    = 16'd3;

	localparam logic [1:0] CFG_MAX_LINE = 2'd0;
	localparam logic [1:0] CFG_WINDOW   = 2'd1;
	localparam logic [1:0] CFG_LIMIT    = 2'd2;

	localparam logic [1:0] CH_TEXT   = 2'd0;
	localparam logic [1:0] CH_HASH   = 2'd1;
	localparam logic [1:0] CH_STATUS = 2'd2;

	localparam logic [7:0] CHR_TAB  = 8'h09;
	localparam logic [7:0] CHR_LF   = 8'h0A;
	localparam logic [7:0] CHR_CR   = 8'h0D;
	localparam logic [7:0] CHR_SP   = 8'h20;
	localparam logic [7:0] CHR_DASH = 8'h2D;
	localparam logic [7:0] CHR_F    = 8'h46;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_CTRL,
		ST_LEN,
		ST_BIN,
		ST_EMIT
	} state_t;

	// Result steps in the order they go out for one transaction.
	typedef enum logic [3:0] {
		STEP_DASH0,
		STEP_DASH1,
		STEP_HELD,
		STEP_TBYTE,
		STEP_BREAK0,
		STEP_BREAK1,
		STEP_SPACE,
		STEP_HBYTE,
		STEP_EOTNL,
		STEP_STATUS
	} step_t;

	localparam int unsigned NUM_STEPS = 10;
	localparam int unsigned STEP_W    = 4;
	typedef logic [NUM_STEPS-1:0] plan_t;

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
	} alu_op_t;

	typedef struct packed {
		logic        lt;
		logic [15:0] inc;
	} alu_res_t;

	// Characters of "From ".
	function automatic logic [7:0] from_char(input logic [2:0] k);
		logic [7:0] c;
		unique case (k)
			3'd0:    c = 8'h46;
			3'd1:    c = 8'h72;
			3'd2:    c = 8'h6F;
			3'd3:    c = 8'h6D;
			3'd4:    c = CHR_SP;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_ctrl(input logic [7:0] b);
		return (b < 8'd32) && (b != CHR_TAB) && (b != CHR_CR) && (b != CHR_LF);
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CHR_CR) || (b == CHR_SP) || (b == CHR_TAB);
	endfunction

endpackage

// ===== src/csc_alu.sv =====
// ----------------------------------------------------------------------------
// csc_alu
// Shared 16-bit compare and saturating increment unit.
// ----------------------------------------------------------------------------
module csc_alu (
	input  csc_pkg::alu_op_t  op,
	output csc_pkg::alu_res_t res
);
	import csc_pkg::*;

	assign res.lt  = op.a < op.b;
	assign res.inc = (op.a == 16'hFFFF) ? op.a : op.a + 16'd1;

endmodule

// ===== src/csc_space_buf.sv =====
// ----------------------------------------------------------------------------
// csc_space_buf
// Buffer for the trailing whitespace run of the current line. One write
// port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csc_space_buf #(
	parameter  int unsigned DEPTH = csc_pkg::SPACE_DEPTH_DEF,
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);
	import csc_pkg::*;

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== src/cleartext_sign_canonicalizer.sv =====
// ----------------------------------------------------------------------------
// cleartext_sign_canonicalizer
// Dash-escapes the signed text and canonicalizes the hash stream of a
// cleartext signature, with sticky long-line, whitespace and binary flags.
//
// Channel   Signals                                   Moves
// text      text_valid, text_ready, text_item        one byte or end of text
// result    result_valid, result_ready, result_item  one output byte or status
// config    cfg_we, cfg_index, cfg_data              one register write
//
// A text byte passes the window, control, length and binary states, an end of
// text only the binary state; results go out one per cycle unless the output
// stalls. The four compares of a byte all pass through the one shared compare
// and increment unit, and results leave through a single output register. The
// block is ready only in idle; a stalled result holds the sequencer. Reset
// clears all control state; the whitespace buffer needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cleartext_sign_canonicalizer #(
	parameter int unsigned SPACE_DEPTH = csc_pkg::SPACE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_ready,
	input  csc_pkg::text_item_t   text_item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output csc_pkg::result_item_t result_item,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data
);
	import csc_pkg::*;

	localparam int unsigned SPACE_CAP = (SPACE_DEPTH < 1) ? 1 :
		((SPACE_DEPTH > SPACE_CAP_MAX) ? SPACE_CAP_MAX : SPACE_DEPTH);
	localparam int unsigned SCNT_W = $clog2(SPACE_CAP + 1);
	localparam int unsigned SIDX_W = (SPACE_CAP > 1) ? $clog2(SPACE_CAP) : 1;
	localparam int unsigned IDX_W  = (SCNT_W > 3) ? SCNT_W : 3;

	state_t state_q, state_d;

	logic [15:0] max_line_length_q, binary_window_q, binary_limit_q;

	logic        at_line_start_q, pending_break_q;
	logic [2:0]  held_count_q, held_n_q;
	logic [SCNT_W-1:0] space_count_q, space_n_q;
	logic [15:0] line_length_q, bytes_seen_q, control_count_q;
	logic [1:0]  err_q;
	logic        suspect_q, in_win_q;

	logic [7:0]  byte_q;
	logic        eot_q;
	plan_t       plan_q;
	logic [IDX_W-1:0] idx_q, idx_d, idx_inc;

	logic         result_valid_q;
	result_item_t result_q;

	alu_op_t  alu_op;
	alu_res_t alu_res;

	step_t  cur_step;
	plan_t  cur_bit;
	logic   rep_done, last, fire, accept;
	logic   nl, ws;
	logic   sp_we;
	logic [7:0] sp_rd;
	logic [7:0] emit_byte;
	logic [1:0] emit_ch;
	logic   emit_space, emit_held, status_out, status_ok;

	csc_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	csc_space_buf #(
		.DEPTH (SPACE_CAP)
	) u_space (
		.clk     (clk),
		.we      (sp_we),
		.wr_addr (space_count_q[SIDX_W-1:0]),
		.wr_data (byte_q),
		.rd_addr (idx_d[SIDX_W-1:0]),
		.rd_data (sp_rd)
	);

	assign nl     = (byte_q == CHR_LF);
	assign ws     = is_ws(byte_q);
	assign accept = text_valid && text_ready;
	assign sp_we  = (state_q == ST_LEN) && !eot_q && !nl && ws &&
		(space_count_q < SCNT_W'(SPACE_CAP));

	// The lowest pending step is the next result to go out.
	always_comb begin
		cur_step = STEP_DASH0;
		for (int i = NUM_STEPS - 1; i >= 0; i--) begin
			if (plan_q[i]) begin
				cur_step = step_t'(STEP_W'(i));
			end
		end
	end

	assign cur_bit = plan_t'(1) << cur_step;
	assign idx_inc = idx_q + 1'b1;

	always_comb begin
		unique case (cur_step)
			STEP_HELD:  rep_done = (idx_inc == IDX_W'(held_n_q));
			STEP_SPACE: rep_done = (idx_inc == IDX_W'(space_n_q));
			default:    rep_done = 1'b1;
		endcase
	end

	assign last = rep_done && ((plan_q & ~cur_bit) == '0);
	assign fire = (state_q == ST_EMIT) && (plan_q != '0) &&
		(!result_valid_q || result_ready);

	always_comb begin
		if (accept) begin
			idx_d = '0;
		end else if (fire) begin
			idx_d = rep_done ? '0 : idx_inc;
		end else begin
			idx_d = idx_q;
		end
	end

	always_comb begin
		unique case (cur_step)
			STEP_DASH0:  begin emit_byte = CHR_DASH;              emit_ch = CH_TEXT;   end
			STEP_DASH1:  begin emit_byte = CHR_SP;                emit_ch = CH_TEXT;   end
			STEP_HELD:   begin emit_byte = from_char(idx_q[2:0]); emit_ch = CH_TEXT;   end
			STEP_TBYTE:  begin emit_byte = byte_q;                emit_ch = CH_TEXT;   end
			STEP_BREAK0: begin emit_byte = CHR_CR;                emit_ch = CH_HASH;   end
			STEP_BREAK1: begin emit_byte = CHR_LF;                emit_ch = CH_HASH;   end
			STEP_SPACE:  begin emit_byte = sp_rd;                 emit_ch = CH_HASH;   end
			STEP_HBYTE:  begin emit_byte = byte_q;                emit_ch = CH_HASH;   end
			STEP_EOTNL:  begin emit_byte = CHR_LF;                emit_ch = CH_TEXT;   end
			default:     begin emit_byte = 8'h00;                 emit_ch = CH_STATUS; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		text_ready = 1'b0;
		alu_op.a   = binary_limit_q;
		alu_op.b   = control_count_q;
		unique case (state_q)
			ST_IDLE: begin
				text_ready = 1'b1;
				if (text_valid) begin
					state_d = text_item.end_of_text ? ST_BIN : ST_WIN;
				end
			end
			ST_WIN: begin
				alu_op.a = bytes_seen_q;
				alu_op.b = binary_window_q;
				state_d  = ST_CTRL;
			end
			ST_CTRL: begin
				alu_op.a = control_count_q;
				alu_op.b = 16'hFFFF;
				state_d  = ST_LEN;
			end
			ST_LEN: begin
				alu_op.a = line_length_q;
				alu_op.b = max_line_length_q;
				state_d  = ST_BIN;
			end
			ST_BIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (plan_q == '0 || (fire && last)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_length_q <= MAX_LINE_RST;
			binary_window_q   <= WINDOW_RST;
			binary_limit_q    <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_LINE: max_line_length_q <= cfg_data;
				CFG_WINDOW:   binary_window_q   <= cfg_data;
				CFG_LIMIT:    binary_limit_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Transaction payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= text_item.text_byte;
			eot_q  <= text_item.end_of_text;
		end
	end

	// Text state, plan of results and the step index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q <= 1'b1;
			pending_break_q <= 1'b0;
			held_count_q    <= '0;
			held_n_q        <= '0;
			space_count_q   <= '0;
			space_n_q       <= '0;
			line_length_q   <= '0;
			bytes_seen_q    <= '0;
			control_count_q <= '0;
			err_q           <= '0;
			suspect_q       <= 1'b0;
			in_win_q        <= 1'b0;
			plan_q          <= '0;
			idx_q           <= '0;
		end else begin
			idx_q <= idx_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						plan_q <= '0;
					end
				end
				ST_WIN: begin
					in_win_q <= alu_res.lt;
					if (alu_res.lt) begin
						bytes_seen_q <= alu_res.inc;
					end
				end
				ST_CTRL: begin
					if (in_win_q && is_ctrl(byte_q)) begin
						control_count_q <= alu_res.inc;
					end
				end
				ST_LEN: begin
					pending_break_q <= nl;
					if (pending_break_q) begin
						plan_q[STEP_BREAK0] <= 1'b1;
						plan_q[STEP_BREAK1] <= 1'b1;
					end
					if (nl) begin
						space_count_q   <= '0;
						line_length_q   <= '0;
					end else begin
						if (!alu_res.lt) begin
							err_q[0] <= 1'b1;
						end
						line_length_q <= alu_res.inc;
						if (ws) begin
							if (sp_we) begin
								space_count_q <= space_count_q + 1'b1;
							end else begin
								err_q[1] <= 1'b1;
							end
						end else begin
							space_n_q          <= space_count_q;
							plan_q[STEP_SPACE] <= (space_count_q != '0);
							plan_q[STEP_HBYTE] <= 1'b1;
							space_count_q      <= '0;
						end
					end
				end
				ST_BIN: begin
					suspect_q <= alu_res.lt;
					held_n_q  <= held_count_q;
					if (eot_q) begin
						plan_q[STEP_HELD]   <= (held_count_q != '0);
						plan_q[STEP_EOTNL]  <= !pending_break_q;
						plan_q[STEP_STATUS] <= 1'b1;
						held_count_q        <= '0;
					end else if (nl) begin
						plan_q[STEP_HELD]  <= (held_count_q != '0);
						plan_q[STEP_TBYTE] <= 1'b1;
						held_count_q       <= '0;
						at_line_start_q    <= 1'b1;
					end else if (held_count_q != '0) begin
						if (held_count_q < 3'd4 && byte_q == from_char(held_count_q)) begin
							held_count_q <= held_count_q + 3'd1;
						end else begin
							// A full "From " line gets the dash escape.
							if (held_count_q == 3'd4 && byte_q == CHR_SP) begin
								plan_q[STEP_DASH0] <= 1'b1;
								plan_q[STEP_DASH1] <= 1'b1;
							end
							plan_q[STEP_HELD]  <= 1'b1;
							plan_q[STEP_TBYTE] <= 1'b1;
							held_count_q       <= '0;
						end
					end else if (at_line_start_q) begin
						at_line_start_q <= 1'b0;
						if (byte_q == CHR_DASH) begin
							plan_q[STEP_DASH0] <= 1'b1;
							plan_q[STEP_DASH1] <= 1'b1;
							plan_q[STEP_TBYTE] <= 1'b1;
						end else if (byte_q == CHR_F) begin
							held_count_q <= 3'd1;
						end else begin
							plan_q[STEP_TBYTE] <= 1'b1;
						end
					end else begin
						plan_q[STEP_TBYTE] <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (fire) begin
						if (rep_done) begin
							plan_q <= plan_q & ~cur_bit;
						end
						// The end of text leaves everything ready for a new text.
						if (last && eot_q) begin
							at_line_start_q <= 1'b1;
							pending_break_q <= 1'b0;
							held_count_q    <= '0;
							space_count_q   <= '0;
							line_length_q   <= '0;
							bytes_seen_q    <= '0;
							control_count_q <= '0;
							err_q           <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.channel        <= emit_ch;
			result_q.out_byte       <= emit_byte;
			result_q.end_of_run     <= last;
			result_q.text_done      <= (cur_step == STEP_STATUS);
			result_q.line_too_long  <= err_q[0];
			result_q.space_overflow <= err_q[1];
			result_q.binary_suspect <= suspect_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

	assign emit_space = (state_q == ST_EMIT) && (plan_q != '0) && (cur_step == STEP_SPACE);
	assign emit_held  = (state_q == ST_EMIT) && (plan_q != '0) && (cur_step == STEP_HELD);
	assign status_out = result_valid && result_item.text_done;
	assign status_ok  = result_item.end_of_run && (result_item.channel == CH_STATUS);

	`CSC_ASSERT(busy_after_accept_a, accept |=> !text_ready, "ready right after accept")
	`CSC_ASSERT_ON(status_last_a, status_out, status_ok, "status result not last")
	`CSC_ASSERT_ON(space_idx_a, emit_space, idx_q < IDX_W'(space_n_q), "space index past run")
	`CSC_ASSERT_ON(held_idx_a, emit_held, idx_q < IDX_W'(held_n_q), "held index past prefix")
	`CSC_ASSERT(space_cnt_a, space_count_q <= SCNT_W'(SPACE_CAP), "space count above depth")

endmodule
